// ===== rtl/mwmf_pkg.sv =====
`default_nettype none

package mwmf_pkg;

   localparam int MAX_ROWS  = 64;
   localparam int MAX_COLS  = 64;
   localparam int WINDOW    = 5;
   localparam int WIN_CELLS = WINDOW * WINDOW;

   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int ADDR_W = ROW_W + COL_W;
   localparam int DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int DIM_W  = 7;
   localparam int H_W    = 16;

   localparam int WIN_IDX_W = $clog2(WINDOW);
   localparam int CNT_W     = $clog2(WIN_CELLS + 1);
   localparam int VIDX_W    = $clog2(WIN_CELLS);

   localparam int REQ_TDATA_W = ((ROW_W + COL_W + H_W + 7) / 8) * 8;
   localparam int REQ_TUSER_W = 1;
   localparam int RSP_TDATA_W = H_W;
   localparam int RSP_TUSER_W = 2;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = DIM_W;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_IN_USE = 1'd1;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GATHER,
      ST_DRAIN,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/masked_window_median_filter.sv =====
`default_nettype none

// channel   dir  tdata (low bit up)                       tuser (low bit up)
// req_      in   row[5:0] col[11:6] height[27:12] pad      req_type
// rsp_      out  filtered_height[15:0]                     had_samples, out_of_range
// csr_      in   csr_we, csr_index (0 rows, 1 cols), csr_wdata
//
// a write in range completes in idle; an out-of-range request goes through done
// a read walks the 25 window cells in gather, reading those inside the map through
// the single height memory read port, drains the last read and loads the result
// reset is synchronous; the height memory is not cleared and must be written first
// a new request is taken while an earlier result still waits on rsp_tready
module masked_window_median_filter (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // row, col, height, zero padding
   input  wire logic [mwmf_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // req_type
   input  wire logic [mwmf_pkg::REQ_TUSER_W-1:0]   req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // filtered_height
   output logic [mwmf_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   // had_samples, out_of_range
   output logic [mwmf_pkg::RSP_TUSER_W-1:0]        rsp_tuser,
   input  wire logic                               csr_we,
   input  wire logic [mwmf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [mwmf_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import mwmf_pkg::*;

   state_type state_ff, state_in;

   logic [DIM_W-1:0]      rows_ff, rows_in, cols_ff, cols_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [WIN_IDX_W-1:0]  wi_ff, wi_in, wj_ff, wj_in;
   logic [CNT_W-1:0]      n_ff, n_in;
   logic                  oor_ff, oor_in;
   logic signed [H_W-1:0] center_ff, center_in;
   logic                  rd_vld_ff, rd_vld_in, rd_first_ff, rd_first_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_TUSER_W-1:0] rsp_user_ff, rsp_user_in;
   logic signed [H_W-1:0] vals_ff [WIN_CELLS];
   logic signed [H_W-1:0] vals_in [WIN_CELLS];

   logic [H_W-1:0]        mem [DEPTH];
   logic signed [H_W-1:0] mem_rd_ff;
   logic                  mem_we, mem_re;
   logic [ADDR_W-1:0]     mem_waddr, mem_raddr;

   logic [ROW_W-1:0]      req_row;
   logic [COL_W-1:0]      req_col;
   logic [H_W-1:0]        req_height;
   logic [DIM_W-1:0]      nr, nc, win_r, win_c;
   logic                  req_oor, win_ok, out_free, ins_en;
   logic [WIN_CELLS-1:0]  gt;
   logic [VIDX_W-1:0]     med_idx;

   assign req_row    = req_tdata[ROW_W-1:0];
   assign req_col    = req_tdata[ROW_W+COL_W-1:ROW_W];
   assign req_height = req_tdata[ROW_W+COL_W+H_W-1:ROW_W+COL_W];

   // dimension registers above the map size act as the map size
   assign nr = (rows_ff > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_ff;
   assign nc = (cols_ff > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : cols_ff;

   assign req_oor = (DIM_W'(req_row) >= nr) || (DIM_W'(req_col) >= nc);

   assign win_r  = DIM_W'(row_ff) + DIM_W'(wi_ff);
   assign win_c  = DIM_W'(col_ff) + DIM_W'(wj_ff);
   assign win_ok = (win_r < nr) && (win_c < nc);

   assign mem_waddr = {req_row, req_col};
   assign mem_raddr = {win_r[ROW_W-1:0], win_c[COL_W-1:0]};
   assign mem_re    = (state_ff == ST_GATHER) && win_ok;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign ins_en   = rd_vld_ff && !mem_rd_ff[H_W-1] && (mem_rd_ff != '0);
   assign med_idx  = VIDX_W'(n_ff >> 1);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // sorted insertion: empty slots count as larger than any sample
   always_comb begin
      for (int k = 0; k < WIN_CELLS; k++) begin
         gt[k] = (CNT_W'(k) >= n_ff) || (vals_ff[k] > mem_rd_ff);
      end
      vals_in[0] = gt[0] ? mem_rd_ff : vals_ff[0];
      for (int k = 1; k < WIN_CELLS; k++) begin
         if (gt[k-1]) begin
            vals_in[k] = vals_ff[k-1];
         end else if (gt[k]) begin
            vals_in[k] = mem_rd_ff;
         end else begin
            vals_in[k] = vals_ff[k];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      wi_in        = wi_ff;
      wj_in        = wj_ff;
      n_in         = n_ff;
      oor_in       = oor_ff;
      center_in    = center_ff;
      rd_vld_in    = 1'b0;
      rd_first_in  = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      mem_we       = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_ROWS_IN_USE: rows_in = csr_wdata;
            CSR_COLS_IN_USE: cols_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               row_in = req_row;
               col_in = req_col;
               oor_in = req_oor;
               if (req_oor) begin
                  state_in = ST_DONE;
               end else if (req_tuser[0] == REQ_WRITE) begin
                  mem_we = 1'b1;
               end else begin
                  state_in = ST_GATHER;
                  wi_in    = '0;
                  wj_in    = '0;
                  n_in     = '0;
               end
            end
         end
         ST_GATHER: begin
            rd_vld_in   = win_ok;
            rd_first_in = (wi_ff == '0) && (wj_ff == '0);
            if (wj_ff == WIN_IDX_W'(WINDOW - 1)) begin
               wj_in = '0;
               if (wi_ff == WIN_IDX_W'(WINDOW - 1)) begin
                  state_in = ST_DRAIN;
               end else begin
                  wi_in = wi_ff + 1'b1;
               end
            end else begin
               wj_in = wj_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (oor_ff) begin
                  rsp_data_in = '0;
                  rsp_user_in = 2'b10;
               end else if (n_ff == '0) begin
                  rsp_data_in = center_ff;
                  rsp_user_in = 2'b00;
               end else begin
                  rsp_data_in = vals_ff[med_idx];
                  rsp_user_in = 2'b01;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (ins_en) begin
         n_in = n_ff + 1'b1;
      end
      // the first window cell is the addressed cell itself
      if (rd_vld_ff && rd_first_ff) begin
         center_in = mem_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rows_ff      <= DIM_W'(MAX_ROWS);
         cols_ff      <= DIM_W'(MAX_COLS);
         wi_ff        <= '0;
         wj_ff        <= '0;
         n_ff         <= '0;
         rd_vld_ff    <= 1'b0;
         rd_first_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         wi_ff        <= wi_in;
         wj_ff        <= wj_in;
         n_ff         <= n_in;
         rd_vld_ff    <= rd_vld_in;
         rd_first_ff  <= rd_first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      col_ff      <= col_in;
      oor_ff      <= oor_in;
      center_ff   <= center_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      if (ins_en) begin
         for (int k = 0; k < WIN_CELLS; k++) begin
            vals_ff[k] <= vals_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= req_height;
      end
      if (mem_re) begin
         mem_rd_ff <= mem[mem_raddr];
      end
   end

`ifndef SYNTHESIS
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the done state");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= CNT_W'(WIN_CELLS))
      else $error("sample count beyond window size");

   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_IDLE))
      else $error("height write while a read is in progress");

   a_read_data_phase: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == ST_GATHER || state_ff == ST_DRAIN))
      else $error("window read data outside gather");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_user_ff[0] && rsp_user_ff[1]))
      else $error("samples flagged on an out-of-range result");
`endif

endmodule

`default_nettype wire
